// ----- design/gclp_pkg.sv -----
// Package for the G-code line prefilter: store size, character codes and
// comment-mode type. No dependencies.
`default_nettype none
package gclp_pkg;

    localparam int LINE_BYTES = 64;
    localparam int CNT_W = $clog2(LINE_BYTES);

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        CM_NONE,
        CM_PAREN,
        CM_SEMI
    } cmode_t;

endpackage
`default_nettype wire

// ----- design/gcode_line_prefilter.sv -----
// Line prefilter for a G-code byte stream: comment stripping, upcasing,
// line store in a synchronous RAM and line drain. Depends on gclp_pkg.
//
// Takes one byte per cycle while a line is being collected; kept characters
// go into a LINE_BYTES-deep single-port-write RAM with registered read. A CR
// or LF ends the line, and the block then drains it, each stored character
// by a RAM read, then a load of the output register once that is free; no
// input word is taken during the drain. An empty line gives one word flagged
// empty. Output words sit in a register, so a waiting result does not stall
// byte collection.
`default_nettype none
module gcode_line_prefilter
    import gclp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_char,
    output logic            last_of_line,
    output logic            empty_line
);

    typedef enum logic [1:0] {
        ST_RUN,
        ST_EMPTY,
        ST_DRAIN_RD,
        ST_DRAIN_WAIT
    } state_t;

    state_t             state_reg;
    cmode_t             cmode_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   len_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               out_valid_reg;
    logic [7:0]         out_char_reg;
    logic               last_reg;
    logic               empty_reg;

    logic [7:0]         line_mem [LINE_BYTES];
    logic [7:0]         rd_data_reg;

    logic               accept;
    logic               is_eol;
    logic               is_drop;
    logic               is_full;
    logic               mem_we;
    logic [7:0]         wr_data;
    logic               out_free;
    logic               out_load;

    assign in_ready     = (state_reg == ST_RUN);
    assign accept       = in_valid && in_ready;
    assign is_eol       = (in_byte == CH_LF) || (in_byte == CH_CR);
    assign is_drop      = (in_byte <= CH_SPACE) || (in_byte == CH_SLASH);
    assign is_full      = ({1'b0, count_reg} >= (CNT_W + 1)'(LINE_BYTES - 1));
    assign out_free     = !out_valid_reg || out_ready;
    assign out_load     = ((state_reg == ST_EMPTY) || (state_reg == ST_DRAIN_WAIT)) && out_free;

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign last_of_line = last_reg;
    assign empty_line   = empty_reg;

    always_comb
    begin
        if (in_byte >= CH_LOWER_A && in_byte <= CH_LOWER_Z)
        begin
            wr_data = in_byte - CH_LOWER_A + CH_UPPER_A;
        end
        else
        begin
            wr_data = in_byte;
        end
        mem_we = accept && !is_eol && (cmode_reg == CM_NONE) && !is_drop
                 && (in_byte != CH_LPAREN) && (in_byte != CH_SEMI) && !is_full;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[count_reg] <= wr_data;
        end
        rd_data_reg <= line_mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cmode_reg     <= CM_NONE;
            count_reg     <= '0;
            len_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            last_reg      <= 1'b0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_RUN:
                begin
                    if (accept)
                    begin
                        if (is_eol)
                        begin
                            cmode_reg  <= CM_NONE;
                            count_reg  <= '0;
                            len_reg    <= count_reg;
                            rd_idx_reg <= '0;
                            state_reg  <= (count_reg == '0) ? ST_EMPTY : ST_DRAIN_RD;
                        end
                        else if (cmode_reg != CM_NONE)
                        begin
                            if (in_byte == CH_RPAREN && cmode_reg == CM_PAREN)
                            begin
                                cmode_reg <= CM_NONE;
                            end
                        end
                        else if (is_drop)
                        begin
                            cmode_reg <= CM_NONE;
                        end
                        else if (in_byte == CH_LPAREN)
                        begin
                            cmode_reg <= CM_PAREN;
                        end
                        else if (in_byte == CH_SEMI)
                        begin
                            cmode_reg <= CM_SEMI;
                        end
                        else if (is_full)
                        begin
                            count_reg <= '0;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                ST_EMPTY:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= '0;
                        last_reg      <= 1'b1;
                        empty_reg     <= 1'b1;
                        state_reg     <= ST_RUN;
                    end
                end
                ST_DRAIN_RD:
                begin
                    state_reg <= ST_DRAIN_WAIT;
                end
                ST_DRAIN_WAIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_char_reg  <= rd_data_reg;
                        empty_reg     <= 1'b0;
                        if (rd_idx_reg == len_reg - 1'b1)
                        begin
                            last_reg  <= 1'b1;
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            last_reg   <= 1'b0;
                            rd_idx_reg <= rd_idx_reg + 1'b1;
                            state_reg  <= ST_DRAIN_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_RUN;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
